### src/dsss_correlator_lock_despreader_core_assert.svh
// assertion macros for the despreader checker
// used by dcld_checker only, expects clock and reset in scope
`ifndef DSSS_CORRELATOR_LOCK_DESPREADER_CORE_ASSERT_SVH
`define DSSS_CORRELATOR_LOCK_DESPREADER_CORE_ASSERT_SVH

// plain property, sampled on the rising clock edge
`define DCLD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition in one cycle implies something in the next
`define DCLD_ASSERT_NEXT(lbl, cond, nxt, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) cond |=> nxt) else $error(msg);

`endif

### src/dcld_pkg.sv
// shared types and constants of the despreader core
// no dependencies
package dcld_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int CORR_W      = 15;
   localparam int MAG_W       = 14;
   localparam int CHIP_W      = 64;
   localparam int LEN_W       = 7;
   localparam int THR_W       = 14;
   localparam int CNT_W       = 6;
   localparam int EV_W        = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int LANES       = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_W-1:0] CHIP_LEN_MAX = LEN_W'(CHIP_W);
   localparam logic [THR_W-1:0] LOCK_THR_RST   = THR_W'(4000);
   localparam logic [THR_W-1:0] UNLOCK_THR_RST = THR_W'(3000);

   typedef enum logic [EV_W-1:0] {
      EV_DATA = 2'd0,
      EV_LOCK = 2'd1,
      EV_LOST = 2'd2
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHIPS      = 2'd0,
      CSR_LEN        = 2'd1,
      CSR_LOCK_THR   = 2'd2,
      CSR_UNLOCK_THR = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_SHIFT  = 2'd0,
      OP_SEARCH = 2'd1,
      OP_CHECK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      B_IDLE   = 2'd0,
      B_CORR   = 2'd1,
      B_DECIDE = 2'd2
   } back_state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_start;
      op_type                     op;
      logic [LEN_W-1:0]           len;
   } job_type;

   typedef struct packed {
      logic valid;
      logic locked;
   } fb_type;

   typedef struct packed {
      logic [CHIP_W-1:0] chips;
      logic [THR_W-1:0]  lock_thr;
      logic [THR_W-1:0]  unlock_thr;
   } cfg_type;

endpackage

### src/dcld_if.sv
// request and response channel interfaces of the despreader core
// depends on dcld_pkg
interface dcld_req_if import dcld_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       frame_start;

   modport source (output valid, output sample, output frame_start, input ready);
   modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface dcld_rsp_if import dcld_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [EV_W-1:0]          event_res;
   logic                     data_bit;
   logic signed [CORR_W-1:0] correlation;

   modport source (output valid, output event_res, output data_bit, output correlation,
                   input ready);
   modport sink   (input valid, input event_res, input data_bit, input correlation,
                   output ready);
endinterface

### src/dsss_correlator_lock_despreader_core.sv
// DSSS despreader: matched filter over the last code_length samples against a +/-1 chip
// pattern, with lock hysteresis. Unlocked, every sample is correlated and a lock event is
// given when |c| exceeds lock_threshold; locked, one sample in code_length is correlated and
// gives a data bit or, when |c| drops below unlock_threshold, a lock lost event. A correlated
// sample passes through the correlator, which sums 8 window taps per cycle over
// ceil(MAX_CODE_LEN/8) lane groups, and the request port stays closed from its acceptance
// until the lock decision is made, and longer while a response is held back. The user must
// write configuration through the csr port only while the block is idle; the block itself
// does not enforce this.
// depends on dcld_pkg, dcld_if, dcld_front, dcld_queue, dcld_back
module dsss_correlator_lock_despreader_core import dcld_pkg::*; #(
   parameter int MAX_CODE_LEN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   dcld_req_if.sink              req_ch,
   dcld_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CHIP_W-1:0] chip_pattern_ff;
   logic [LEN_W-1:0]  code_length_ff;
   logic [THR_W-1:0]  lock_thr_ff;
   logic [THR_W-1:0]  unlock_thr_ff;

   cfg_type cfg;
   fb_type  fb;
   job_type push_job;
   job_type head;
   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_pattern_ff <= '0;
         code_length_ff  <= CHIP_LEN_MAX;
         lock_thr_ff     <= LOCK_THR_RST;
         unlock_thr_ff   <= UNLOCK_THR_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CHIPS:      chip_pattern_ff <= csr_wdata[CHIP_W-1:0];
            CSR_LEN:        code_length_ff  <= csr_wdata[LEN_W-1:0];
            CSR_LOCK_THR:   lock_thr_ff     <= csr_wdata[THR_W-1:0];
            CSR_UNLOCK_THR: unlock_thr_ff   <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.chips      = chip_pattern_ff;
   assign cfg.lock_thr   = lock_thr_ff;
   assign cfg.unlock_thr = unlock_thr_ff;

   dcld_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .code_length (code_length_ff),
      .q_full      (q_full),
      .fb          (fb),
      .push        (push),
      .job         (push_job)
   );

   dcld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   dcld_back #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .head  (head),
      .empty (q_empty),
      .pop   (pop),
      .fb    (fb),
      .rsp   (rsp_ch)
   );

endmodule

### src/dcld_front.sv
// front end: takes requests, tracks lock and the bit countdown, classifies each request
// depends on dcld_pkg and dcld_req_if
module dcld_front import dcld_pkg::*; #(
   parameter int MAX_CODE_LEN = 64
) (
   input  logic             clock,
   input  logic             reset,
   dcld_req_if.sink         req,
   input  logic [LEN_W-1:0] code_length,
   input  logic             q_full,
   input  fb_type           fb,
   output logic             push,
   output job_type          job
);

   logic             locked_ff, locked_in;
   logic             pending_ff, pending_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] eff_len;
   logic             accept;

   always_comb begin
      if (code_length == '0) begin
         eff_len = LEN_W'(1);
      end else if (code_length > LEN_W'(MAX_CODE_LEN)) begin
         eff_len = LEN_W'(MAX_CODE_LEN);
      end else begin
         eff_len = code_length;
      end
   end

   // a correlating request holds the front until the back reports the lock outcome
   assign req.ready = !pending_ff && !q_full;
   assign accept    = req.valid && req.ready;
   assign push      = accept;

   always_comb begin
      job.sample      = req.sample;
      job.frame_start = req.frame_start;
      job.len         = eff_len;
      if (locked_ff && count_ff != '0) begin
         job.op = OP_SHIFT;
      end else if (locked_ff) begin
         job.op = OP_CHECK;
      end else begin
         job.op = OP_SEARCH;
      end
   end

   always_comb begin
      locked_in  = locked_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      if (accept) begin
         if (job.op == OP_SHIFT) begin
            count_in = count_ff - CNT_W'(1);
         end else begin
            count_in   = CNT_W'(eff_len - LEN_W'(1));
            pending_in = 1'b1;
         end
      end
      if (fb.valid) begin
         locked_in  = fb.locked;
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff  <= 1'b0;
         pending_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         locked_ff  <= locked_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

endmodule

### src/dcld_queue.sv
// short job queue between the front end and the correlator back end
// depends on dcld_pkg
module dcld_queue import dcld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    full,
   output logic    empty
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head  = entry_ff[rd_ptr_ff];
   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/dcld_back.sv
// back end: sample window, lane-parallel correlator, lock decision and response register
// depends on dcld_pkg and dcld_rsp_if
module dcld_back import dcld_pkg::*; #(
   parameter int MAX_CODE_LEN = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  job_type  head,
   input  logic     empty,
   output logic     pop,
   output fb_type   fb,
   dcld_rsp_if.source rsp
);

   localparam int GROUPS    = (MAX_CODE_LEN + LANES - 1) / LANES;
   localparam int WIN_DEPTH = GROUPS * LANES;
   localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   back_state_type             state_ff, state_in;
   logic signed [SAMPLE_W-1:0] window_ff [WIN_DEPTH];
   logic signed [SAMPLE_W-1:0] window_in [WIN_DEPTH];
   logic [GRP_W-1:0]           grp_ff, grp_in;
   logic signed [CORR_W-1:0]   acc_ff, acc_in;
   logic [CHIP_W-1:0]          chips_ff, chips_in;
   logic [LEN_W-1:0]           remain_ff, remain_in;
   op_type                     op_ff, op_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   event_type                  ev_ff, ev_in;
   logic                       bit_ff, bit_in;
   logic signed [CORR_W-1:0]   corr_ff, corr_in;

   logic signed [CORR_W-1:0]   lane_sum;
   logic signed [CORR_W-1:0]   term;
   logic signed [CORR_W-1:0]   mag_s;
   logic [MAG_W-1:0]           mag;
   logic                       out_free;
   logic                       emit;
   logic                       new_locked;
   event_type                  dec_ev;
   logic                       dec_bit;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.event_res   = ev_ff;
   assign rsp.data_bit    = bit_ff;
   assign rsp.correlation = corr_ff;
   assign out_free        = !rsp_valid_ff || rsp.ready;

   // lanes see window taps 0..LANES-1, chip for lane j sits at the top of the aligned pattern
   always_comb begin
      lane_sum = '0;
      term     = '0;
      for (int j = 0; j < LANES; j++) begin
         if (LEN_W'(j) < remain_ff) begin
            term = CORR_W'(window_ff[j]);
            if (chips_ff[CHIP_W-1-j]) begin
               lane_sum = lane_sum + term;
            end else begin
               lane_sum = lane_sum - term;
            end
         end
      end
   end

   always_comb begin
      mag_s      = acc_ff[CORR_W-1] ? -acc_ff : acc_ff;
      mag        = mag_s[MAG_W-1:0];
      emit       = 1'b0;
      new_locked = 1'b0;
      dec_ev     = EV_DATA;
      dec_bit    = 1'b0;
      case (op_ff)
         OP_SEARCH: begin
            emit       = mag > cfg.lock_thr;
            new_locked = emit;
            dec_ev     = EV_LOCK;
         end
         OP_CHECK: begin
            emit = 1'b1;
            if (mag < cfg.unlock_thr) begin
               dec_ev     = EV_LOST;
               new_locked = 1'b0;
            end else begin
               dec_ev     = EV_DATA;
               new_locked = 1'b1;
               dec_bit    = !acc_ff[CORR_W-1] && acc_ff != '0;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      grp_in       = grp_ff;
      acc_in       = acc_ff;
      chips_in     = chips_ff;
      remain_in    = remain_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      ev_in        = ev_ff;
      bit_in       = bit_ff;
      corr_in      = corr_ff;
      pop          = 1'b0;
      fb           = '0;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               for (int k = 0; k < WIN_DEPTH; k++) begin
                  if (k == 0) begin
                     window_in[k] = head.sample;
                  end else if (head.frame_start) begin
                     window_in[k] = '0;
                  end else begin
                     window_in[k] = window_ff[k-1];
                  end
               end
               if (head.op != OP_SHIFT) begin
                  state_in  = B_CORR;
                  grp_in    = '0;
                  acc_in    = '0;
                  chips_in  = cfg.chips << (CHIP_LEN_MAX - head.len);
                  remain_in = head.len;
                  op_in     = head.op;
               end
            end
         end
         B_CORR: begin
            acc_in    = acc_ff + lane_sum;
            chips_in  = chips_ff << LANES;
            remain_in = (remain_ff > LEN_W'(LANES)) ? remain_ff - LEN_W'(LANES) : '0;
            // the ring turns by one lane group per cycle and is back in place after the pass
            for (int k = 0; k < WIN_DEPTH; k++) begin
               if (k + LANES < WIN_DEPTH) begin
                  window_in[k] = window_ff[k + LANES];
               end else begin
                  window_in[k] = window_ff[k + LANES - WIN_DEPTH];
               end
            end
            if (grp_ff == GRP_W'(GROUPS - 1)) begin
               state_in = B_DECIDE;
            end else begin
               grp_in = grp_ff + GRP_W'(1);
            end
         end
         B_DECIDE: begin
            if (!emit || out_free) begin
               fb.valid  = 1'b1;
               fb.locked = new_locked;
               state_in  = B_IDLE;
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  ev_in        = dec_ev;
                  bit_in       = dec_bit;
                  corr_in      = acc_ff;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < WIN_DEPTH; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff    <= grp_in;
      acc_ff    <= acc_in;
      chips_ff  <= chips_in;
      remain_ff <= remain_in;
      op_ff     <= op_in;
      ev_ff     <= ev_in;
      bit_ff    <= bit_in;
      corr_ff   <= corr_in;
   end

endmodule

### src/dcld_checker.sv
// port-level checks on the response channel of the despreader core, bound to the top level
// depends on dcld_pkg and dsss_correlator_lock_despreader_core_assert.svh
`include "dsss_correlator_lock_despreader_core_assert.svh"

module dcld_checker import dcld_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [EV_W-1:0]          event_res,
   input logic                     data_bit,
   input logic signed [CORR_W-1:0] correlation
);

   `DCLD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `DCLD_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(event_res) && $stable(data_bit) && $stable(correlation), "response changed while stalled")
   `DCLD_ASSERT(a_bit_only_data, rsp_valid && event_res != EV_DATA |-> !data_bit, "data bit set on a lock event")
   `DCLD_ASSERT(a_bit_sign, rsp_valid && event_res == EV_DATA |-> data_bit == (!correlation[CORR_W-1] && correlation != '0), "data bit disagrees with correlation sign")
   `DCLD_ASSERT(a_lock_nonzero, rsp_valid && event_res == EV_LOCK |-> correlation != '0, "lock acquired on zero correlation")

endmodule

bind dsss_correlator_lock_despreader_core dcld_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .event_res   (rsp_ch.event_res),
   .data_bit    (rsp_ch.data_bit),
   .correlation (rsp_ch.correlation)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for the dsss despreader core: random sample traffic with lock prediction
// depends on dcld_pkg, dcld_if and dsss_correlator_lock_despreader_core
module testbench;
   import dcld_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 600;
   localparam int REPORT_MAX   = 20;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smp;
      logic                       fs;
   } sample_req_type;

   typedef struct packed {
      event_type                ev;
      logic                     data_bit;
      logic signed [CORR_W-1:0] corr;
   } despread_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dcld_req_if req_ch ();
   dcld_rsp_if rsp_ch ();

   dsss_correlator_lock_despreader_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sample_req_type      pending_q [$];
   despread_result_type expected_q [$];

   // own copy of the despreader state and settings
   logic signed [SAMPLE_W-1:0] win_q [CHIP_W];
   logic                       pred_locked;
   logic [CNT_W-1:0]           check_countdown;
   logic [CHIP_W-1:0]          chips_cfg;
   logic [LEN_W-1:0]           len_cfg;
   logic [THR_W-1:0]           lock_cfg;
   logic [THR_W-1:0]           unlock_cfg;

   bit  req_idling;
   bit  rsp_idling;
   int  gap_left;
   int  stall_left;
   int  hold_left;
   int  next_hold_at;
   int  holds_done;
   int  requests_sent;
   int  results_seen;
   int  lock_events;
   int  data_events;
   int  lost_events;
   int  fail_count;
   int  settings_run;
   int  cycle_count;
   logic hold_off;

   assign hold_off = (hold_left != 0);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int eff_len(logic [LEN_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > CHIP_LEN_MAX) return CHIP_W;
      return int'(raw);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] to_sample(int v);
      if (v > 127) return 8'sd127;
      if (v < -128) return -8'sd128;
      return SAMPLE_W'(v);
   endfunction

   task automatic predict_sample(input logic signed [SAMPLE_W-1:0] smp, input logic fs);
      int                  len;
      int                  acc;
      int                  mag;
      bit                  emit;
      despread_result_type res;
      len  = eff_len(len_cfg);
      acc  = 0;
      emit = 1'b0;
      res  = '0;
      if (fs) begin
         foreach (win_q[i]) win_q[i] = '0;
      end
      for (int i = CHIP_W - 1; i > 0; i--) win_q[i] = win_q[i-1];
      win_q[0] = smp;
      if (pred_locked && check_countdown != '0) begin
         check_countdown = check_countdown - CNT_W'(1);
      end else begin
         // newest sample meets the last chip
         for (int i = 0; i < len; i++) begin
            if (chips_cfg[len-1-i]) acc += win_q[i];
            else acc -= win_q[i];
         end
         mag = (acc < 0) ? -acc : acc;
         if (pred_locked) begin
            emit = 1'b1;
            if (mag < int'(unlock_cfg)) begin
               pred_locked     = 1'b0;
               check_countdown = '0;
               res.ev          = EV_LOST;
            end else begin
               check_countdown = CNT_W'(len - 1);
               res.ev          = EV_DATA;
               res.data_bit    = (acc > 0);
            end
         end else if (mag > int'(lock_cfg)) begin
            emit            = 1'b1;
            pred_locked     = 1'b1;
            check_countdown = CNT_W'(len - 1);
            res.ev          = EV_LOCK;
         end
      end
      if (emit) begin
         res.corr = acc[CORR_W-1:0];
         expected_q.push_back(res);
      end
   endtask

   // driver: offers pending requests with random gaps
   always @(posedge clock) begin : drive_proc
      sample_req_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_sample(req_ch.sample, req_ch.frame_start);
            requests_sent <= requests_sent + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0 || pending_q.size() == 0) begin
               req_ch.valid <= 1'b0;
               if (gap_left != 0) gap_left <= gap_left - 1;
            end else begin
               item = pending_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.sample      <= item.smp;
               req_ch.frame_start <= item.fs;
               gap_left           <= req_idling ? pick_gap() : 0;
            end
         end
      end
   end

   // monitor: random back-pressure and in-order checking
   always @(posedge clock) begin : check_proc
      despread_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
            case (rsp_ch.event_res)
               EV_LOCK: lock_events++;
               EV_DATA: data_events++;
               default: lost_events++;
            endcase
            if (expected_q.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("%0t: unexpected result event %0d bit %0d corr %0d", $time,
                           rsp_ch.event_res, rsp_ch.data_bit, rsp_ch.correlation);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.event_res !== want.ev || rsp_ch.data_bit !== want.data_bit ||
                   rsp_ch.correlation !== want.corr) begin
                  if (fail_count < REPORT_MAX)
                     $display("%0t: expected event %0d bit %0d corr %0d, got %0d %0d %0d",
                              $time, want.ev, want.data_bit, want.corr, rsp_ch.event_res,
                              rsp_ch.data_bit, rsp_ch.correlation);
                  fail_count++;
               end
            end
         end
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
         end else if (rsp_idling && $urandom_range(0, 99) < 30) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= pick_gap();
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the core backs up and closes its request port
   always @(posedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         next_hold_at <= 40;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (results_seen >= next_hold_at) begin
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + 300;
         holds_done   <= holds_done + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[dsss_correlator_lock_despreader_core] ERROR");
         $finish;
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
         @(negedge clock);
      // requests with no result may still be in the correlator
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CHIPS:    chips_cfg  = val;
         CSR_LEN:      len_cfg    = val[LEN_W-1:0];
         CSR_LOCK_THR: lock_cfg   = val[THR_W-1:0];
         default:      unlock_cfg = val[THR_W-1:0];
      endcase
   endtask

   task automatic apply_settings(input logic [CHIP_W-1:0] chips, input logic [LEN_W-1:0] len,
                                 input logic [THR_W-1:0] lock_thr,
                                 input logic [THR_W-1:0] unlock_thr);
      wait_idle();
      write_register(CSR_CHIPS, chips);
      write_register(CSR_LEN, len);
      write_register(CSR_LOCK_THR, lock_thr);
      write_register(CSR_UNLOCK_THR, unlock_thr);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      settings_run++;
   endtask

   task automatic push_raw(input int v, input logic fs);
      sample_req_type item;
      item.smp = to_sample(v);
      item.fs  = fs;
      pending_q.push_back(item);
   endtask

   // one spread data bit, or its first count samples
   task automatic push_symbol(input logic [CHIP_W-1:0] chips, input logic data_val,
                              input int amp, input int noise, input logic fs, input int count);
      int v;
      for (int k = 0; k < count; k++) begin
         v = (chips[k] == data_val) ? amp : -amp;
         if (noise > 0) v += int'($urandom_range(0, 2 * noise)) - noise;
         push_raw(v, fs && k == 0);
      end
   endtask

   task automatic run_random(input logic [CHIP_W-1:0] chips, input logic [LEN_W-1:0] len_raw,
                             input logic [THR_W-1:0] lock_thr,
                             input logic [THR_W-1:0] unlock_thr, input int n_items,
                             input bit idling);
      int len;
      int made;
      int r;
      int amp;
      int cut;
      apply_settings(chips, len_raw, lock_thr, unlock_thr);
      req_idling = idling;
      rsp_idling = idling;
      len  = eff_len(len_raw);
      made = 0;
      while (made < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 68) begin
            // mostly strong symbols, some weak enough to lose lock
            amp = ($urandom_range(0, 99) < 80) ? $urandom_range(70, 127) : $urandom_range(0, 40);
            push_symbol(chips, $urandom_range(0, 1), amp, 15, $urandom_range(0, 99) < 4, len);
            made += len;
         end else if (r < 80) begin
            cut = $urandom_range(1, len);
            push_symbol(chips, $urandom_range(0, 1), $urandom_range(60, 127), 15, 1'b0, cut);
            made += cut;
         end else if (r < 93) begin
            cut = $urandom_range(1, 8);
            repeat (cut) push_raw(int'($urandom_range(0, 255)) - 128, $urandom_range(0, 99) < 8);
            made += cut;
         end else begin
            // single stray sample shifts the chip alignment
            push_raw(int'($urandom_range(0, 40)) - 20, 1'b0);
            made++;
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.sample      = '0;
      req_ch.frame_start = 1'b0;
      rsp_ch.ready = 1'b0;
      foreach (win_q[i]) win_q[i] = '0;
      pred_locked     = 1'b0;
      check_countdown = '0;
      chips_cfg  = '0;
      len_cfg    = CHIP_LEN_MAX;
      lock_cfg   = LOCK_THR_RST;
      unlock_cfg = UNLOCK_THR_RST;
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single chip: threshold edges, extreme samples, frame start
      apply_settings({CHIP_W{1'b1}}, 7'd1, 14'd100, 14'd50);
      push_raw(0, 1'b1);
      push_raw(127, 1'b0);
      push_raw(-128, 1'b0);
      push_raw(127, 1'b0);
      push_raw(0, 1'b0);
      push_raw(-128, 1'b1);
      push_raw(60, 1'b0);
      push_raw(50, 1'b0);
      push_raw(49, 1'b0);
      push_raw(100, 1'b0);
      push_raw(101, 1'b0);
      push_raw(-50, 1'b0);
      push_raw(-49, 1'b0);

      // four chips: lock, a data bit from the data 0 symbol, cleared window drops the lock
      apply_settings(64'hA, 7'd4, 14'd300, 14'd200);
      push_symbol(64'hA, 1'b1, 127, 0, 1'b1, 4);
      push_symbol(64'hA, 1'b0, 127, 0, 1'b0, 4);
      push_symbol(64'hA, 1'b0, 0, 0, 1'b1, 4);

      run_random({$urandom, $urandom}, 7'd8, 14'd360, 14'd240, 150, 1'b1);
      run_random({$urandom, $urandom}, 7'd64, LOCK_THR_RST, UNLOCK_THR_RST, 150, 1'b0);
      run_random({CHIP_W{1'b1}}, 7'd1, 14'd45, 14'd30, 120, 1'b1);
      run_random('0, 7'd0, 14'd45, 14'd30, 100, 1'b1);
      run_random({$urandom, $urandom}, 7'd127, 14'd2880, 14'd1920, 100, 1'b1);
      // lock can never be acquired, an old lock may still run on
      run_random({$urandom, $urandom}, 7'd100, 14'd16383, 14'd1920, 100, 1'b1);
      // any nonzero sum locks and the lock is never lost
      run_random({$urandom, $urandom}, 7'd5, 14'd0, 14'd0, 150, 1'b0);
      run_random({$urandom, $urandom}, 7'd16, 14'd8192, 14'd16383, 100, 1'b1);
      run_random({$urandom, $urandom}, 7'd3, 14'd135, 14'd90, 200, 1'b1);
      run_random({$urandom, $urandom}, 7'd12, 14'd540, 14'd360, 200, 1'b1);
      run_random({$urandom, $urandom}, 7'd33, 14'd1485, 14'd990, 150, 1'b0);
      run_random({$urandom, $urandom}, 7'd2, 14'd90, 14'd60, 200, 1'b1);
      run_random({$urandom, $urandom}, 7'd64, 14'd8191, 14'd1920, 80, 1'b1);

      wait_idle();
      $display("ran %0d requests under %0d register settings, %0d receiver hold-offs",
               requests_sent, settings_run, holds_done);
      $display("results checked: %0d lock, %0d data bit, %0d lock lost",
               lock_events, data_events, lost_events);
      if (fail_count == 0) begin
         $display("[dsss_correlator_lock_despreader_core] OK");
      end else begin
         $display("[dsss_correlator_lock_despreader_core] ERROR");
      end
      $finish;
   end

endmodule
